[rtl/core/lease_periodic_task_scheduler_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lease periodic task scheduler
// Immediate-implication and next-cycle forms on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef LEASE_PERIODIC_TASK_SCHEDULER_TOP_ASSERT_SVH
`define LEASE_PERIODIC_TASK_SCHEDULER_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define LPTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpts assertion failed");

// check cons in the cycle after ante
`define LPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpts assertion failed");

`endif

[rtl/core/lpts_pkg.sv]
// ----------------------------------------------------------------------------
// lpts_pkg
// Types and constants of the lease periodic task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lpts_pkg;

  typedef enum logic [2:0] {
    OP_SCHEDULE  = 3'd0,
    OP_RENEW     = 3'd1,
    OP_RENEW_ALL = 3'd2,
    OP_CANCEL    = 3'd3,
    OP_QUERY     = 3'd4,
    OP_TICK      = 3'd5
  } lpts_op_e;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_EMIT   = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_PAUSED = 2'd2;

  localparam logic [31:0] US_PER_MS = 32'd1000;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] interval;
    logic [31:0] next_due;
    logic [31:0] deadline;
    logic        lease_on;
    logic        emit_en;
    logic        expire_en;
  } lpts_entry_t;

endpackage

`default_nettype wire

[rtl/core/lpts_ram.sv]
// ----------------------------------------------------------------------------
// lpts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/lease_periodic_task_scheduler_top.sv]
// A table of TASK_SLOTS periodic tasks held in one slot RAM with a registered
// read; active flags live in flip-flops and clear at reset. Every operation
// but a paused tick or an unknown opcode walks the slots in ascending order:
// an inactive slot is passed over in S_LOAD, while an active slot examined is
// read, evaluated and written back (S_LOAD, S_EVAL, S_COMMIT), because each
// slot goes through a read-modify-write on the single RAM read port. A lookup
// stops at its hit, and an item waits while the result side stalls; a paused
// tick or an unknown opcode goes straight to its ack.
// ----------------------------------------------------------------------------
// lease_periodic_task_scheduler_top
// Periodic task table with lease expiry, emit and expire events.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lease_periodic_task_scheduler_top_assert.svh"

module lease_periodic_task_scheduler_top #(
  parameter int TASK_SLOTS = 8,
  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // task_id[7:0], period_us[39:8], lease_len[62:40], emit_enabled[63],
  // expire_notify[64], now_us[96:65], paused[97], zero[103:98]
  input  wire logic [103:0] s_axis_tdata_i,
  // opcode[2:0]
  input  wire logic [2:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // task_id_res[7:0], slot[10:8], status[12:11], is_active[13], zero[15:14]
  output logic [15:0]       m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  import lpts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_LOAD, S_EVAL, S_COMMIT, S_DONE, S_ACK
  } state_e;

  localparam int EW = $bits(lpts_entry_t);

  state_e state_q;

  logic [2:0]  op_q;
  logic [7:0]  id_q;
  logic [31:0] ivl_q;
  logic [31:0] now_q;
  logic [31:0] prod_q;
  logic [31:0] dl_q;
  logic        lease_on_q;
  logic        emit_q;
  logic        exp_q;
  logic        paused_q;

  logic [SW-1:0]         idx_q;
  logic [TASK_SLOTS-1:0] active_q;

  lpts_entry_t ent_q;
  logic        match_q;
  logic        lease_hit_q;
  logic        due_hit_q;
  logic [31:0] behind_q;

  logic [7:0] ack_id_q;
  logic [2:0] ack_slot_q;
  logic [1:0] ack_status_q;
  logic       ack_act_q;

  logic       m_valid_q;
  logic       m_valid_d;
  logic [1:0] m_kind_q;
  logic [7:0] m_id_q;
  logic [2:0] m_slot_q;
  logic [1:0] m_status_q;
  logic       m_act_q;
  logic       m_last_q;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  lpts_entry_t   ram_wdata;
  logic          ram_re;
  logic [EW-1:0] ram_rdata;
  lpts_entry_t   rd_ent;

  logic          s_accept;
  logic          out_free;
  logic          idx_last;
  logic          free_any;
  logic [SW-1:0] free_idx;
  logic [31:0]   diff_lease;
  logic [31:0]   diff_due;
  logic [31:0]   next_due_new;
  logic          ev_need;
  logic          commit_stall;
  logic          tick_paused;
  lpts_entry_t   sched_ent;
  lpts_entry_t   lease_ent;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign idx_last        = (idx_q == SW'(TASK_SLOTS - 1));
  assign free_any        = ~&active_q;
  assign rd_ent          = lpts_entry_t'(ram_rdata);
  assign diff_lease      = now_q - rd_ent.deadline;
  assign diff_due        = now_q - rd_ent.next_due;
  assign next_due_new    = (behind_q > ent_q.interval) ? (now_q + ent_q.interval)
                                                       : (ent_q.next_due + ent_q.interval);
  assign ev_need         = lease_hit_q ? ent_q.expire_en : (due_hit_q && ent_q.emit_en);
  assign commit_stall    = (op_q == OP_TICK) && ev_need && !out_free;
  assign ram_re          = (state_q == S_LOAD) && active_q[idx_q];
  assign tick_paused     = (op_q == OP_TICK) && paused_q;
  assign m_valid_d       = ((state_q == S_COMMIT) && (op_q == OP_TICK) && ev_need && out_free) ||
                           ((state_q == S_ACK) && out_free) ||
                           (m_valid_q && !m_axis_tready_i);

  always_comb begin
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    sched_ent           = ent_q;
    sched_ent.id        = id_q;
    sched_ent.interval  = ivl_q;
    sched_ent.next_due  = now_q;
    sched_ent.deadline  = dl_q;
    sched_ent.lease_on  = lease_on_q;
    sched_ent.emit_en   = emit_q;
    sched_ent.expire_en = exp_q;
    lease_ent           = ent_q;
    lease_ent.deadline  = dl_q;
    lease_ent.lease_on  = lease_on_q;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ent_q;
    if (state_q == S_COMMIT) begin
      priority case (op_q)
        OP_SCHEDULE: begin
          ram_we    = match_q;
          ram_wdata = sched_ent;
          if (ent_q.interval == ivl_q) begin
            ram_wdata.next_due = ent_q.next_due;
          end
        end
        OP_RENEW: begin
          ram_we    = match_q;
          ram_wdata = lease_ent;
        end
        OP_RENEW_ALL: begin
          ram_we    = 1'b1;
          ram_wdata = lease_ent;
        end
        OP_TICK: begin
          ram_we             = !lease_hit_q && due_hit_q && !commit_stall;
          ram_wdata.next_due = next_due_new;
        end
        default: ram_we = 1'b0;
      endcase
    end else if (state_q == S_DONE && op_q == OP_SCHEDULE) begin
      ram_we    = free_any;
      ram_waddr = free_idx;
      ram_wdata = sched_ent;
    end
  end

  lpts_ram #(
    .WIDTH(EW),
    .DEPTH(TASK_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= '0;
      m_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            op_q       <= s_axis_tuser_i;
            id_q       <= s_axis_tdata_i[7:0];
            ivl_q      <= s_axis_tdata_i[39:8];
            prod_q     <= 32'({9'd0, s_axis_tdata_i[62:40]} * US_PER_MS);
            lease_on_q <= (s_axis_tdata_i[62:40] != 23'd0);
            emit_q     <= s_axis_tdata_i[63];
            exp_q      <= s_axis_tdata_i[64];
            now_q      <= s_axis_tdata_i[96:65];
            paused_q   <= s_axis_tdata_i[97];
            state_q    <= S_PREP;
          end
        end
        S_PREP: begin
          dl_q         <= lease_on_q ? (now_q + prod_q) : 32'd0;
          idx_q        <= '0;
          ack_id_q     <= tick_paused ? 8'd0 : id_q;
          ack_slot_q   <= 3'd0;
          ack_status_q <= tick_paused ? ST_PAUSED : ST_MISS;
          ack_act_q    <= 1'b0;
          if (op_q > OP_TICK) begin
            state_q <= S_ACK;
          end else if (tick_paused) begin
            state_q <= S_ACK;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (active_q[idx_q]) begin
            state_q <= S_EVAL;
          end else if (idx_last) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end
        S_EVAL: begin
          ent_q       <= rd_ent;
          match_q     <= (rd_ent.id == id_q);
          lease_hit_q <= rd_ent.lease_on && !diff_lease[31];
          due_hit_q   <= !diff_due[31];
          behind_q    <= diff_due;
          state_q     <= S_COMMIT;
        end
        S_COMMIT: begin
          if ((op_q == OP_SCHEDULE || op_q == OP_RENEW || op_q == OP_CANCEL ||
               op_q == OP_QUERY) && match_q) begin
            if (op_q == OP_CANCEL) begin
              active_q[idx_q] <= 1'b0;
            end
            ack_slot_q   <= 3'(idx_q);
            ack_status_q <= ST_OK;
            ack_act_q    <= (op_q == OP_QUERY);
            state_q      <= S_ACK;
          end else if (!commit_stall) begin
            if (op_q == OP_TICK) begin
              if (lease_hit_q) begin
                active_q[idx_q] <= 1'b0;
              end
              if (ev_need) begin
                m_kind_q   <= lease_hit_q ? KIND_EXPIRE : KIND_EMIT;
                m_id_q     <= ent_q.id;
                m_slot_q   <= 3'(idx_q);
                m_status_q <= ST_OK;
                m_act_q    <= 1'b0;
                m_last_q   <= 1'b0;
              end
            end
            if (idx_last) begin
              state_q <= S_DONE;
            end else begin
              idx_q   <= idx_q + SW'(1);
              state_q <= S_LOAD;
            end
          end
        end
        S_DONE: begin
          if (op_q == OP_SCHEDULE) begin
            if (free_any) begin
              active_q[free_idx] <= 1'b1;
              ack_slot_q         <= 3'(free_idx);
              ack_status_q       <= ST_OK;
            end
          end else if (op_q == OP_RENEW_ALL || op_q == OP_TICK) begin
            ack_id_q     <= 8'd0;
            ack_status_q <= ST_OK;
          end
          state_q <= S_ACK;
        end
        S_ACK: begin
          if (out_free) begin
            m_kind_q   <= KIND_ACK;
            m_id_q     <= ack_id_q;
            m_slot_q   <= ack_slot_q;
            m_status_q <= ack_status_q;
            m_act_q    <= ack_act_q;
            m_last_q   <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_act_q, m_status_q, m_slot_q, m_id_q};
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

  `LPTS_ASSERT_SAME(a_last_marks_ack, clk_i, rst_ni, m_valid_q,
                    (m_kind_q == KIND_ACK) == m_last_q)
  `LPTS_ASSERT_SAME(a_commit_slot_active, clk_i, rst_ni, state_q == S_COMMIT,
                    active_q[idx_q])
  `LPTS_ASSERT_SAME(a_write_in_update, clk_i, rst_ni, ram_we,
                    state_q == S_COMMIT || state_q == S_DONE)
  `LPTS_ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, s_accept,
                    !s_axis_tready_o && state_q == S_PREP)

endmodule

`default_nettype wire
